// ===== rtl/tsd_pkg.sv =====
// Shared definitions for the scratchpad temperature decoder.
// Register indexes, reset codes, status and kind codes, and the queue entry type.
// No dependencies.
package tsd_pkg;

	// Depth of the queue between the front and the back.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Configuration port widths.
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CODE_W = 8;

	// Result temperature width and saturation bounds.
	localparam int unsigned TEMP_W = 22;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -22'sd1282500;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 22'sd1279375;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_CODE_STANDARD  = 2'd0,
		REG_CODE_LEGACY    = 2'd1,
		REG_CODE_VARIANT_A = 2'd2,
		REG_CODE_VARIANT_B = 2'd3
	} reg_idx_t;

	localparam logic [CODE_W-1:0] RST_CODE_STANDARD  = 8'd40;
	localparam logic [CODE_W-1:0] RST_CODE_LEGACY    = 8'd16;
	localparam logic [CODE_W-1:0] RST_CODE_VARIANT_A = 8'd34;
	localparam logic [CODE_W-1:0] RST_CODE_VARIANT_B = 8'd66;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_FAMILY = 2'd1,
		STATUS_BAD_CRC    = 2'd2,
		STATUS_CONV_ERR   = 2'd3
	} status_t;

	// How the front classified a word's family code.
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_STD  = 2'd1,
		KIND_LEG  = 2'd2
	} kind_t;

	// One classified scratchpad word as it travels through the queue.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] temp_lsb;
		logic [7:0] temp_msb;
		logic [7:0] alarm_high;
		logic [7:0] alarm_low;
		logic [7:0] config_byte;
		logic [7:0] reserved_byte;
		logic [7:0] count_remain;
		logic [7:0] count_per_degree;
		logic [7:0] crc_byte;
	} entry_t;

	// Queue head as seen by the back.
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_head_t;

endpackage

// ===== rtl/tsd_front.sv =====
// Front of the scratchpad temperature decoder: configuration registers and
// family classification of incoming words. Depends on tsd_pkg.
module tsd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tsd_pkg::ADDR_W-1:0]   paddr,
	input  logic [tsd_pkg::DATA_W-1:0]   pwdata,
	output logic [tsd_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   family_code,
	input  logic [7:0]                   temp_lsb,
	input  logic [7:0]                   temp_msb,
	input  logic [7:0]                   alarm_high,
	input  logic [7:0]                   alarm_low,
	input  logic [7:0]                   config_byte,
	input  logic [7:0]                   reserved_byte,
	input  logic [7:0]                   count_remain,
	input  logic [7:0]                   count_per_degree,
	input  logic [7:0]                   crc_byte,
	input  logic                         q_full,
	output logic                         push,
	output tsd_pkg::entry_t              push_entry
);

	logic [tsd_pkg::CODE_W-1:0] code_standard_q;
	logic [tsd_pkg::CODE_W-1:0] code_legacy_q;
	logic [tsd_pkg::CODE_W-1:0] code_variant_a_q;
	logic [tsd_pkg::CODE_W-1:0] code_variant_b_q;
	tsd_pkg::reg_idx_t          reg_idx;
	logic                       wr_en;
	logic [tsd_pkg::CODE_W-1:0] rd_code;

	assign pready  = 1'b1;
	assign reg_idx = tsd_pkg::reg_idx_t'(paddr[tsd_pkg::ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_standard_q  <= tsd_pkg::RST_CODE_STANDARD;
			code_legacy_q    <= tsd_pkg::RST_CODE_LEGACY;
			code_variant_a_q <= tsd_pkg::RST_CODE_VARIANT_A;
			code_variant_b_q <= tsd_pkg::RST_CODE_VARIANT_B;
		end else if (wr_en) begin
			case (reg_idx)
				tsd_pkg::REG_CODE_STANDARD:  code_standard_q  <= pwdata[tsd_pkg::CODE_W-1:0];
				tsd_pkg::REG_CODE_LEGACY:    code_legacy_q    <= pwdata[tsd_pkg::CODE_W-1:0];
				tsd_pkg::REG_CODE_VARIANT_A: code_variant_a_q <= pwdata[tsd_pkg::CODE_W-1:0];
				tsd_pkg::REG_CODE_VARIANT_B: code_variant_b_q <= pwdata[tsd_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tsd_pkg::REG_CODE_STANDARD:  rd_code = code_standard_q;
			tsd_pkg::REG_CODE_LEGACY:    rd_code = code_legacy_q;
			tsd_pkg::REG_CODE_VARIANT_A: rd_code = code_variant_a_q;
			tsd_pkg::REG_CODE_VARIANT_B: rd_code = code_variant_b_q;
			default:                     rd_code = '0;
		endcase
	end

	assign prdata = {{(tsd_pkg::DATA_W - tsd_pkg::CODE_W){1'b0}}, rd_code};

	// The legacy code wins when a family matches several registers.
	always_comb begin
		if (family_code == code_legacy_q) begin
			push_entry.kind = tsd_pkg::KIND_LEG;
		end else if (family_code == code_standard_q || family_code == code_variant_a_q ||
				family_code == code_variant_b_q) begin
			push_entry.kind = tsd_pkg::KIND_STD;
		end else begin
			push_entry.kind = tsd_pkg::KIND_NONE;
		end
		push_entry.temp_lsb         = temp_lsb;
		push_entry.temp_msb         = temp_msb;
		push_entry.alarm_high       = alarm_high;
		push_entry.alarm_low        = alarm_low;
		push_entry.config_byte      = config_byte;
		push_entry.reserved_byte    = reserved_byte;
		push_entry.count_remain     = count_remain;
		push_entry.count_per_degree = count_per_degree;
		push_entry.crc_byte         = crc_byte;
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

// ===== rtl/tsd_queue.sv =====
// Small queue of classified words between the front and the back.
// Depends on tsd_pkg.
module tsd_queue #(
	parameter int unsigned DEPTH = tsd_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tsd_pkg::entry_t   push_entry,
	input  logic              pop,
	output tsd_pkg::q_head_t  head,
	output logic              full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tsd_pkg::entry_t   slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = slot_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== rtl/tsd_back.sv =====
// Back of the scratchpad temperature decoder: CRC check, standard and legacy
// decode, and the output register. Depends on tsd_pkg.
module tsd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tsd_pkg::q_head_t                    head,
	output logic                                pop,
	output logic                                busy,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tsd_pkg::TEMP_W-1:0]   temperature,
	output logic [1:0]                          status
);

	localparam int unsigned DVD_W      = 18;
	localparam int unsigned BITS_CYC   = 3;
	localparam int unsigned DIV_CYCLES = DVD_W / BITS_CYC;
	localparam int unsigned NUM_BYTES  = 8;
	localparam logic [2:0]  STEP_STD   = 3'd0;
	localparam logic [2:0]  STEP_FLOOR = 3'd6;
	localparam logic [2:0]  STEP_LAST  = 3'd7;
	localparam logic [7:0]  CRC_POLY   = 8'h8C;

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_RUN  = 3'b010,
		BK_DONE = 3'b100
	} back_state_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	back_state_t               state_q;
	logic [2:0]                step_q;
	tsd_pkg::entry_t           ent_q;
	logic [7:0]                crc_q;
	logic [7:0]                rem_q;
	logic [DVD_W-1:0]          dvd_q;
	logic                      dneg_q;
	logic signed [21:0]        std_q;
	logic signed [17:0]        base_q;
	logic signed [18:0]        f_q;
	logic signed [19:0]        lq_q;
	logic                      out_valid_q;
	logic signed [21:0]        temp_q;
	tsd_pkg::status_t          status_q;

	logic                      out_free;
	logic                      write_out;
	logic [7:0]                pad [NUM_BYTES];
	logic [8:0]                ld_diff;
	logic [7:0]                ld_mag;
	logic [DVD_W-1:0]          ld_dvd;
	logic [7:0]                div_rem;
	logic [DVD_W-1:0]          div_dvd;
	logic [8:0]                div_r;
	logic [15:0]               s_raw;
	logic [15:0]               s_mag;
	logic [3:0]                s_keep;
	logic [20:0]               s_val;
	logic signed [21:0]        s_signed;
	logic [8:0]                l_m;
	logic signed [8:0]         l_half;
	logic signed [17:0]        l_base;
	logic signed [18:0]        l_qs;
	logic signed [18:0]        l_f;
	logic signed [19:0]        l_sum;
	logic signed [23:0]        l_ext;
	logic signed [23:0]        l_v10;
	logic signed [21:0]        l_temp;
	tsd_pkg::status_t          fin_status;
	logic signed [21:0]        fin_temp;

	assign out_free  = !out_valid_q || !out_stall;
	assign write_out = (state_q == BK_DONE) && out_free;
	assign pop       = head.valid && ((state_q == BK_IDLE) || write_out);
	assign busy      = (state_q != BK_IDLE);

	// Scratchpad bytes in CRC order.
	always_comb begin
		pad[0] = ent_q.temp_lsb;
		pad[1] = ent_q.temp_msb;
		pad[2] = ent_q.alarm_high;
		pad[3] = ent_q.alarm_low;
		pad[4] = ent_q.config_byte;
		pad[5] = ent_q.reserved_byte;
		pad[6] = ent_q.count_remain;
		pad[7] = ent_q.count_per_degree;
	end

	// Legacy fraction numerator magnitude, 1000 * |per - remain|.
	always_comb begin
		ld_diff = {1'b0, head.entry.count_per_degree} - {1'b0, head.entry.count_remain};
		ld_mag  = ld_diff[8] ? 8'(-ld_diff) : ld_diff[7:0];
		ld_dvd  = DVD_W'(ld_mag) * DVD_W'(1000);
	end

	// Three restoring division steps per cycle.
	always_comb begin
		div_rem = rem_q;
		div_dvd = dvd_q;
		div_r   = '0;
		for (int k = 0; k < BITS_CYC; k++) begin
			div_r   = {div_rem, div_dvd[DVD_W-1]};
			div_dvd = {div_dvd[DVD_W-2:0], 1'b0};
			if (div_r >= {1'b0, ent_q.count_per_degree}) begin
				div_r      = div_r - {1'b0, ent_q.count_per_degree};
				div_dvd[0] = 1'b1;
			end
			div_rem = div_r[7:0];
		end
	end

	// Standard two's-complement decode.
	always_comb begin
		s_raw = {ent_q.temp_msb, ent_q.temp_lsb};
		s_mag = s_raw[15] ? (16'h0000 - s_raw) : s_raw;
		case (ent_q.config_byte[6:5])
			2'd0:    s_keep = 4'b1000;
			2'd1:    s_keep = 4'b1100;
			2'd2:    s_keep = 4'b1110;
			default: s_keep = 4'b1111;
		endcase
		s_val    = 21'(s_mag[10:4]) * 21'd10000 + 21'(s_mag[3:0] & s_keep) * 21'd625;
		s_signed = s_raw[15] ? -$signed({1'b0, s_val}) : $signed({1'b0, s_val});
	end

	// Legacy base in thousandths and the floored fraction quotient.
	always_comb begin
		l_m = 9'd256 - {1'b0, ent_q.temp_lsb};
		if (ent_q.temp_msb == 8'd0) begin
			l_half = $signed({2'b00, ent_q.temp_lsb[7:1]});
		end else begin
			l_half = -$signed({1'b0, 8'((l_m + 9'd1) >> 1)});
		end
		l_base = $signed({{9{l_half[8]}}, l_half}) * 18'sd1000 - 18'sd250;
		l_qs   = $signed({1'b0, dvd_q});
		if (!dneg_q) begin
			l_f = l_qs;
		end else if (rem_q != 8'd0) begin
			l_f = -l_qs - 19'sd1;
		end else begin
			l_f = -l_qs;
		end
		// A nonzero remainder pulls a negative sum back toward zero.
		l_sum = $signed({base_q[17], base_q[17], base_q}) + $signed({f_q[18], f_q});
		if (l_sum < 0 && rem_q != 8'd0) begin
			l_sum = l_sum + 20'sd1;
		end
		l_ext = $signed({{4{lq_q[19]}}, lq_q});
		l_v10 = (l_ext <<< 3) + (l_ext <<< 1);
		if (l_v10 < $signed({{2{tsd_pkg::TEMP_MIN[21]}}, tsd_pkg::TEMP_MIN})) begin
			l_temp = tsd_pkg::TEMP_MIN;
		end else if (l_v10 > $signed({{2{tsd_pkg::TEMP_MAX[21]}}, tsd_pkg::TEMP_MAX})) begin
			l_temp = tsd_pkg::TEMP_MAX;
		end else begin
			l_temp = l_v10[21:0];
		end
	end

	always_comb begin
		fin_temp = '0;
		if (ent_q.kind == tsd_pkg::KIND_NONE) begin
			fin_status = tsd_pkg::STATUS_BAD_FAMILY;
		end else if (crc_q != ent_q.crc_byte) begin
			fin_status = tsd_pkg::STATUS_BAD_CRC;
		end else if (ent_q.kind == tsd_pkg::KIND_LEG) begin
			if (ent_q.count_per_degree == 8'd0) begin
				fin_status = tsd_pkg::STATUS_CONV_ERR;
			end else begin
				fin_status = tsd_pkg::STATUS_OK;
				fin_temp   = l_temp;
			end
		end else begin
			fin_status = tsd_pkg::STATUS_OK;
			fin_temp   = std_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (pop) begin
						state_q <= BK_RUN;
						step_q  <= '0;
					end
				end
				BK_RUN: begin
					step_q <= step_q + 3'd1;
					if (step_q == STEP_LAST) begin
						state_q <= BK_DONE;
					end
				end
				BK_DONE: begin
					if (write_out) begin
						step_q  <= '0;
						state_q <= pop ? BK_RUN : BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
			if (write_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q  <= head.entry;
			crc_q  <= '0;
			rem_q  <= '0;
			dvd_q  <= ld_dvd;
			dneg_q <= ld_diff[8];
		end else if (state_q == BK_RUN) begin
			crc_q <= crc8_byte(crc_q, pad[step_q]);
			if (step_q < 3'(DIV_CYCLES)) begin
				rem_q <= div_rem;
				dvd_q <= div_dvd;
			end
			if (step_q == STEP_STD) begin
				std_q <= s_signed;
			end
			if (step_q == STEP_FLOOR) begin
				base_q <= l_base;
				f_q    <= l_f;
			end
			if (step_q == STEP_LAST) begin
				lq_q <= l_sum;
			end
		end
		if (write_out) begin
			temp_q   <= fin_temp;
			status_q <= fin_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign temperature = temp_q;
	assign status      = status_q;

endmodule

// ===== rtl/temp_scratchpad_decoder_unit.sv =====
// Top level of the scratchpad temperature decoder.
// Instantiates tsd_front, tsd_queue and tsd_back; depends on tsd_pkg.
//
// Usage: each input word carries a sensor family code and the nine scratchpad
// bytes that the sensor returned. A word is taken at a rising clock edge where
// in_valid is high and in_stall is low. Each word gives exactly one result
// word (temperature in ten-thousandths of a degree C, and status), presented
// on out_valid and taken at an edge where out_stall is low.
// The front checks the family code against the four code registers and places
// the word in a small queue. The back runs a CRC8 check one scratchpad byte
// per cycle while a divider works out the legacy count fraction three
// quotient bits per cycle. Each word runs through eight CRC steps and then a
// done state that forms the result once the output register is free. The back
// takes another word from the queue in the same cycle that it writes a result.
// While the receiver stalls, the result holds in the output register, the
// back finishes its current word and waits, and the queue keeps accepting
// words until it is full, at which point in_stall rises.
// Reset clears the queue, the back and the output valid, and loads the code
// registers with their default family codes. Code registers are written
// through the APB-style port, which never inserts wait states.
module temp_scratchpad_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = tsd_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tsd_pkg::ADDR_W-1:0]          paddr,
	input  logic [tsd_pkg::DATA_W-1:0]          pwdata,
	output logic [tsd_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          family_code,
	input  logic [7:0]                          temp_lsb,
	input  logic [7:0]                          temp_msb,
	input  logic [7:0]                          alarm_high,
	input  logic [7:0]                          alarm_low,
	input  logic [7:0]                          config_byte,
	input  logic [7:0]                          reserved_byte,
	input  logic [7:0]                          count_remain,
	input  logic [7:0]                          count_per_degree,
	input  logic [7:0]                          crc_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tsd_pkg::TEMP_W-1:0]   temperature,
	output logic [1:0]                          status
);

	logic              q_full;
	logic              push;
	tsd_pkg::entry_t   push_entry;
	logic              pop;
	tsd_pkg::q_head_t  head;
	logic              back_busy;

	tsd_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.family_code      (family_code),
		.temp_lsb         (temp_lsb),
		.temp_msb         (temp_msb),
		.alarm_high       (alarm_high),
		.alarm_low        (alarm_low),
		.config_byte      (config_byte),
		.reserved_byte    (reserved_byte),
		.count_remain     (count_remain),
		.count_per_degree (count_per_degree),
		.crc_byte         (crc_byte),
		.q_full           (q_full),
		.push             (push),
		.push_entry       (push_entry)
	);

	tsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full)
	);

	tsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.busy        (back_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.temperature (temperature),
		.status      (status)
	);

	// Any result other than a good decode carries a zero temperature.
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != tsd_pkg::STATUS_OK) |-> temperature == '0)
		else $error("nonzero temperature with error status");

	// Decoded temperatures stay within the saturation bounds.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (temperature >= tsd_pkg::TEMP_MIN) && (temperature <= tsd_pkg::TEMP_MAX))
		else $error("temperature out of range");

	// The queue can only fill up while the back is working on a word.
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> back_busy)
		else $error("queue full while back is idle");

endmodule
